@@ hw/rtl/bouncing_level_ramp_defines.svh @@
// Assertion macros used by the port-level checker file
`ifndef BOUNCING_LEVEL_RAMP_DEFINES_SVH
`define BOUNCING_LEVEL_RAMP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define BLR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blr: implication check failed");

// next-cycle implication
`define BLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blr: next-cycle check failed");

`endif

@@ hw/rtl/blr_pkg.sv @@
// Shared codes, constants and the smooth ramp step for the bouncing level ramp
package blr_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_LOAD  = 2'd3;

  localparam logic [1:0] CFG_FLOOR   = 2'd0;
  localparam logic [1:0] CFG_CEILING = 2'd1;
  localparam logic [1:0] CFG_STEPS   = 2'd2;
  localparam logic [1:0] CFG_STYLE   = 2'd3;

  localparam logic [1:0] DIR_HOLD = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  localparam logic [7:0] FREQ_LO       = 8'd1;
  localparam logic [7:0] FREQ_HI       = 8'd255;
  localparam logic [7:0] FREQ_RESET    = 8'd12;
  localparam logic [7:0] MEM_RESET     = 8'd128;
  localparam logic [7:0] FLOOR_RESET   = 8'd1;
  localparam logic [7:0] CEIL_RESET    = 8'd255;
  localparam logic [7:0] STEPS_RESET   = 8'd7;
  localparam logic [7:0] STEPS_DEFAULT = 8'd7;
  localparam logic [7:0] STEPS_MIN     = 8'd2;
  localparam logic [7:0] LEVEL_MAX     = 8'd255;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] dir;
  } ramp_t;

  // one unit of movement, bouncing at lo and hi
  function automatic ramp_t smooth_tick(input logic [7:0] v, input logic [7:0] lo,
                                        input logic [7:0] hi, input logic [1:0] dir);
    ramp_t r;
    r.value = v;
    r.dir   = dir;
    if (dir == DIR_UP) begin
      if ({1'b0, v} + 9'd1 < {1'b0, hi}) begin
        r.value = v + 8'd1;
      end else begin
        r.value = hi;
        r.dir   = DIR_DOWN;
      end
    end else if (dir == DIR_DOWN) begin
      if ({1'b0, v} > {1'b0, lo} + 9'd1) begin
        r.value = v - 8'd1;
      end else begin
        r.value = lo;
        r.dir   = DIR_UP;
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/bouncing_level_ramp.sv @@
// Bouncing brightness / strobe frequency ramp with a shared multiplier and serial divider
//
//   channel | signals                                         | moves
//   --------+-------------------------------------------------+--------------------
//   in      | in_valid, in_ready, operation .. load_level     | one operation word
//   out     | out_valid, out_ready, brightness .. led_update  | one result word
//   cfg     | cfg_we, cfg_index, cfg_data                     | one register write
//
// A word goes from acceptance through the decode state to the done state, which loads the
// result register; a stepped brightness tick runs, in between, two 16/8 divisions through
// one radix-4 serial divider, each fed by the shared 8x8 multiplier. in_ready is high only
// when the sequencer is idle and out of reset, so one word is in work at a time.
// The result register holds a finished word while out_ready is low.
// rst is synchronous and restores the settings, the ramp state and the control state.
module bouncing_level_ramp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        operation,
  input  logic signed [1:0] ramp_dir,
  input  logic              select_frequency,
  input  logic [7:0]        load_level,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        brightness,
  output logic [7:0]        frequency_index,
  output logic signed [1:0] direction_now,
  output logic [7:0]        remembered_level,
  output logic              led_update
);
  import blr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_DIV1   = 4'd3;
  localparam logic [3:0] S_ADJ    = 4'd4;
  localparam logic [3:0] S_MUL2   = 4'd5;
  localparam logic [3:0] S_DIV2   = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]  state;
  logic [2:0]  div_cnt;
  logic [1:0]  op_r;
  logic [1:0]  dir_in_r;
  logic        sel_r;
  logic [7:0]  load_r;

  logic [7:0]  level_floor;
  logic [7:0]  level_ceiling;
  logic [7:0]  step_count;
  logic        stepped_style;

  logic [7:0]  level_reg;
  logic [7:0]  freq_reg;
  logic [1:0]  dir_reg;
  logic        ramp_running;
  logic        ramp_on_freq;
  logic [7:0]  memory_level;
  logic        led_r;

  logic [15:0] div_q;
  logic [7:0]  div_rem;
  logic [7:0]  div_d;
  logic [7:0]  idx_r;

  logic [7:0]  hi_eff;
  logic [7:0]  range_raw;
  logic [7:0]  range_eff;
  logic [7:0]  steps_m1;
  logic [7:0]  diff;
  logic [7:0]  mul_a;
  logic [7:0]  mul_b;
  logic [15:0] prod;
  logic [8:0]  t1;
  logic [8:0]  t2;
  logic [7:0]  r1;
  logic [7:0]  r2;
  logic        b1;
  logic        b2;
  logic [15:0] q_next;
  logic [7:0]  rem_next;
  logic [16:0] q17;
  logic [7:0]  idx_next;
  logic [1:0]  adj_dir;
  logic [8:0]  sum9;
  logic [7:0]  level_sat;
  logic [1:0]  start_dir;
  ramp_t       freq_tick;
  ramp_t       lvl_tick;

  assign in_ready = (state == S_IDLE) && !rst;

  // effective bounds and step spacing
  always_comb begin
    hi_eff    = (level_ceiling < level_floor) ? level_floor : level_ceiling;
    range_raw = hi_eff - level_floor;
    range_eff = (range_raw == 8'd0) ? 8'd1 : range_raw;
    steps_m1  = (step_count < STEPS_MIN) ? (STEPS_DEFAULT - 8'd1) : (step_count - 8'd1);
    diff      = (level_reg > level_floor) ? (level_reg - level_floor) : 8'd0;
  end

  // shared multiplier: diff * (steps-1), then index * range
  always_comb begin
    if (state == S_MUL1) begin
      mul_a = diff;
      mul_b = steps_m1;
    end else begin
      mul_a = idx_r;
      mul_b = range_eff;
    end
    prod = {8'd0, mul_a} * {8'd0, mul_b};
  end

  // restoring divider, two quotient bits a cycle
  always_comb begin
    t1 = {div_rem, div_q[15]};
    b1 = (t1 >= {1'b0, div_d});
    r1 = b1 ? 8'(t1 - {1'b0, div_d}) : t1[7:0];
    t2 = {r1, div_q[14]};
    b2 = (t2 >= {1'b0, div_d});
    r2 = b2 ? 8'(t2 - {1'b0, div_d}) : t2[7:0];
    q_next   = {div_q[13:0], b1, b2};
    rem_next = r2;
  end

  // move the rounded step index one place and bounce at the ends
  always_comb begin
    q17      = {1'b0, div_q};
    idx_next = div_q[7:0];
    adj_dir  = dir_reg;
    if (dir_reg == DIR_UP) begin
      if (q17 >= {9'd0, steps_m1}) begin
        idx_next = steps_m1;
        adj_dir  = DIR_DOWN;
      end else begin
        idx_next = div_q[7:0] + 8'd1;
      end
    end else begin
      // hold direction steps down as well
      if (div_q == 16'd0) begin
        idx_next = 8'd0;
        adj_dir  = DIR_UP;
      end else if (q17 >= {9'd0, steps_m1} + 17'd2) begin
        idx_next = steps_m1;
        adj_dir  = DIR_DOWN;
      end else begin
        idx_next = div_q[7:0] - 8'd1;
      end
    end
  end

  always_comb begin
    sum9      = {1'b0, level_floor} + {1'b0, div_q[7:0]};
    level_sat = sum9[8] ? LEVEL_MAX : sum9[7:0];
    freq_tick = smooth_tick(freq_reg, FREQ_LO, FREQ_HI, dir_reg);
    lvl_tick  = smooth_tick(level_reg, level_floor, hi_eff, dir_reg);
    case (dir_in_r)
      2'b01:   start_dir = DIR_UP;
      2'b00:   start_dir = DIR_HOLD;
      default: start_dir = DIR_DOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_floor   <= FLOOR_RESET;
      level_ceiling <= CEIL_RESET;
      step_count    <= STEPS_RESET;
      stepped_style <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLOOR:   level_floor   <= cfg_data;
        CFG_CEILING: level_ceiling <= cfg_data;
        CFG_STEPS:   step_count    <= cfg_data;
        CFG_STYLE:   stepped_style <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_cnt      <= 3'd0;
      level_reg    <= 8'd0;
      freq_reg     <= FREQ_RESET;
      dir_reg      <= DIR_HOLD;
      ramp_running <= 1'b0;
      ramp_on_freq <= 1'b0;
      memory_level <= MEM_RESET;
      led_r        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= operation;
            dir_in_r <= ramp_dir;
            sel_r    <= select_frequency;
            load_r   <= load_level;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (op_r)
            OP_TICK: begin
              if (ramp_running && !ramp_on_freq && stepped_style) begin
                led_r <= 1'b1;
                state <= S_MUL1;
              end else begin
                led_r <= ramp_running && !ramp_on_freq;
                state <= S_DONE;
                if (ramp_running) begin
                  if (ramp_on_freq) begin
                    freq_reg <= freq_tick.value;
                    dir_reg  <= freq_tick.dir;
                  end else begin
                    level_reg <= lvl_tick.value;
                    dir_reg   <= lvl_tick.dir;
                  end
                end
              end
            end
            OP_START: begin
              dir_reg      <= start_dir;
              ramp_running <= 1'b1;
              ramp_on_freq <= sel_r;
              led_r        <= 1'b0;
              state        <= S_DONE;
            end
            OP_STOP: begin
              dir_reg <= DIR_HOLD;
              if (ramp_running && !ramp_on_freq) memory_level <= level_reg;
              ramp_running <= 1'b0;
              led_r        <= 1'b0;
              state        <= S_DONE;
            end
            OP_LOAD: begin
              level_reg <= load_r;
              led_r     <= 1'b1;
              state     <= S_DONE;
            end
          endcase
        end
        S_MUL1: begin
          // half the range added for round-to-nearest
          div_q   <= prod + {9'd0, range_eff[7:1]};
          div_d   <= range_eff;
          div_rem <= 8'd0;
          div_cnt <= 3'd0;
          state   <= S_DIV1;
        end
        S_DIV1: begin
          div_q   <= q_next;
          div_rem <= rem_next;
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) state <= S_ADJ;
        end
        S_ADJ: begin
          idx_r   <= idx_next;
          dir_reg <= adj_dir;
          state   <= S_MUL2;
        end
        S_MUL2: begin
          div_q   <= prod;
          div_d   <= steps_m1;
          div_rem <= 8'd0;
          div_cnt <= 3'd0;
          state   <= S_DIV2;
        end
        S_DIV2: begin
          div_q   <= q_next;
          div_rem <= rem_next;
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) state <= S_FIN;
        end
        S_FIN: begin
          level_reg <= level_sat;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            brightness       <= level_reg;
            frequency_index  <= freq_reg;
            direction_now    <= dir_reg;
            remembered_level <= memory_level;
            led_update       <= led_r;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/blr_checker.sv @@
// Port-level checks for the bouncing level ramp, bound to the top level
`include "bouncing_level_ramp_defines.svh"

module blr_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        brightness,
  input logic [7:0]        frequency_index,
  input logic signed [1:0] direction_now,
  input logic [7:0]        remembered_level,
  input logic              led_update
);

  logic [26:0] out_word;

  assign out_word = {brightness, frequency_index, direction_now, remembered_level, led_update};

  // one word at a time: busy right after an accept
  `BLR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  `BLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  `BLR_ASSERT_IMP(a_dir_code, out_valid, direction_now != 2'b10)

  // frequency bounces between 1 and 255, never reaches zero
  `BLR_ASSERT_IMP(a_freq_nonzero, out_valid, frequency_index != 8'd0)

endmodule

bind bouncing_level_ramp blr_checker u_blr_checker (.*);

@@ test/bouncing_level_ramp_test.sv @@
// Self-checking testbench for the bouncing brightness / strobe frequency ramp
module bouncing_level_ramp_test;
  import blr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 30;   // longer than a stepped brightness tick
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_WORDS = 20;
  localparam int unsigned SWEEP_TICKS = 256;
  localparam logic [1:0]  DIR_MINUS_TWO = 2'b10;  // decoded as down

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] freq;
    logic [1:0] dir;
    logic [7:0] memory;
    logic       led;
  } ramp_word_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] dir;
    logic       sel;
    logic [7:0] load;
    logic       typed;
    ramp_word_t want;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] floor_lvl;
    logic [7:0] ceiling_lvl;
    logic [7:0] steps;
    logic       stepped;
  } ramp_setting_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = CFG_FLOOR;
  logic [7:0]        cfg_data = 8'd0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        operation = OP_TICK;
  logic signed [1:0] ramp_dir = DIR_HOLD;
  logic              select_frequency = 1'b0;
  logic [7:0]        load_level = 8'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        brightness;
  logic [7:0]        frequency_index;
  logic signed [1:0] direction_now;
  logic [7:0]        remembered_level;
  logic              led_update;

  bouncing_level_ramp dut (.*);

  always #1 clk = ~clk;

  // predictor copy of the block's registers
  logic [7:0] floor_q, ceiling_q, steps_q;
  logic       style_q;
  logic [7:0] level_q, freq_q, memory_q;
  logic [1:0] dir_q;
  logic       running_q, on_freq_q;

  ramp_word_t  pending_words[$];
  ramp_word_t  oldest_word;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  stim_row_t directed_rows [0:24] = '{
    '{OP_TICK,  DIR_HOLD,      1'b0, 8'h00, 1'b1, '{8'd0, FREQ_RESET, DIR_HOLD, MEM_RESET, 1'b0}},
    '{OP_STOP,  DIR_UP,        1'b1, 8'hFF, 1'b1, '{8'd0, FREQ_RESET, DIR_HOLD, MEM_RESET, 1'b0}},
    '{OP_LOAD,  DIR_DOWN,      1'b0, 8'h00, 1'b1, '{8'd0, FREQ_RESET, DIR_HOLD, MEM_RESET, 1'b1}},
    '{OP_LOAD,  DIR_HOLD,      1'b1, 8'hFF, 1'b1, '{8'd255, FREQ_RESET, DIR_HOLD, MEM_RESET, 1'b1}},
    '{OP_START, DIR_UP,        1'b0, 8'h00, 1'b1, '{8'd255, FREQ_RESET, DIR_UP, MEM_RESET, 1'b0}},
    '{OP_TICK,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_LOAD,  DIR_HOLD,      1'b0, 8'h00, 1'b1, '{8'd0, FREQ_RESET, DIR_DOWN, MEM_RESET, 1'b1}},
    '{OP_TICK,  DIR_DOWN,      1'b1, 8'hFF, 1'b0, '0},
    '{OP_TICK,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_START, DIR_HOLD,      1'b0, 8'h55, 1'b0, '0},
    '{OP_TICK,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_START, DIR_MINUS_TWO, 1'b0, 8'hAA, 1'b0, '0},
    '{OP_TICK,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_STOP,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_START, DIR_DOWN,      1'b1, 8'h00, 1'b0, '0},
    '{OP_TICK,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_TICK,  DIR_UP,        1'b1, 8'hAA, 1'b0, '0},
    '{OP_LOAD,  DIR_HOLD,      1'b0, 8'h55, 1'b0, '0},
    '{OP_TICK,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_STOP,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_START, DIR_UP,        1'b1, 8'h00, 1'b0, '0},
    '{OP_TICK,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_START, DIR_HOLD,      1'b1, 8'h00, 1'b0, '0},
    '{OP_TICK,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0},
    '{OP_STOP,  DIR_HOLD,      1'b0, 8'h00, 1'b0, '0}
  };

  ramp_setting_t fixed_settings [0:6] = '{
    '{8'd0,   8'd255, 8'd0,   1'b1},
    '{8'd255, 8'd0,   8'd1,   1'b1},
    '{8'd100, 8'd100, 8'd2,   1'b1},
    '{8'd0,   8'd255, 8'd255, 1'b1},
    '{8'd20,  8'd200, 8'd5,   1'b1},
    '{8'd0,   8'd255, 8'd7,   1'b0},
    '{8'd200, 8'd10,  8'd3,   1'b0}
  };

  // move v one unit towards the current end, turning round at lo or hi
  function automatic logic [7:0] bounce_unit(input logic [7:0] v, input logic [7:0] lo,
                                             input logic [7:0] hi);
    int vi, loi, hii;
    vi  = int'(v);
    loi = int'(lo);
    hii = int'(hi);
    if (dir_q == DIR_UP) begin
      if (vi < hii - 1) vi++;
      else begin
        vi    = hii;
        dir_q = DIR_DOWN;
      end
    end else if (dir_q == DIR_DOWN) begin
      if (vi > loi + 1) vi--;
      else begin
        vi    = loi;
        dir_q = DIR_UP;
      end
    end
    return vi[7:0];
  endfunction

  // snap to the nearest level, then move one level; hold counts as down
  function automatic void step_level();
    int unsigned lo, hi, steps, span, diff, val;
    int idx;
    lo    = 32'(floor_q);
    hi    = 32'((ceiling_q < floor_q) ? floor_q : ceiling_q);
    steps = 32'((steps_q < STEPS_MIN) ? STEPS_DEFAULT : steps_q);
    span  = hi - lo;
    diff  = (32'(level_q) > lo) ? 32'(level_q) - lo : 0;
    if (span == 0) span = 1;
    idx = int'((diff * (steps - 1) + span / 2) / span);
    if (dir_q == DIR_UP) idx++;
    else idx--;
    if (idx >= int'(steps)) begin
      idx   = int'(steps) - 1;
      dir_q = DIR_DOWN;
    end
    if (idx < 0) begin
      idx   = 0;
      dir_q = DIR_UP;
    end
    val     = lo + (idx * span) / (steps - 1);
    level_q = (val > 32'(LEVEL_MAX)) ? LEVEL_MAX : val[7:0];
  endfunction

  function automatic ramp_word_t next_ramp_word(input logic [1:0] op, input logic [1:0] dir,
                                                input logic sel, input logic [7:0] load);
    ramp_word_t w;
    logic led;
    led = 1'b0;
    case (op)
      OP_TICK: begin
        if (running_q) begin
          if (on_freq_q) freq_q = bounce_unit(freq_q, FREQ_LO, FREQ_HI);
          else begin
            if (style_q) step_level();
            else level_q = bounce_unit(level_q, floor_q,
                                       (ceiling_q < floor_q) ? floor_q : ceiling_q);
            led = 1'b1;
          end
        end
      end
      OP_START: begin
        dir_q     = (dir == DIR_UP) ? DIR_UP : ((dir == DIR_HOLD) ? DIR_HOLD : DIR_DOWN);
        running_q = 1'b1;
        on_freq_q = sel;
      end
      OP_STOP: begin
        dir_q = DIR_HOLD;
        if (running_q && !on_freq_q) memory_q = level_q;
        running_q = 1'b0;
      end
      default: begin
        level_q = load;
        led     = 1'b1;
      end
    endcase
    w.level  = level_q;
    w.freq   = freq_q;
    w.dir    = dir_q;
    w.memory = memory_q;
    w.led    = led;
    return w;
  endfunction

  task automatic offer_word(input logic [1:0] op, input logic [1:0] dir, input logic sel,
                            input logic [7:0] load, input logic typed, input ramp_word_t want);
    ramp_word_t w;
    operation        <= op;
    ramp_dir         <= dir;
    select_frequency <= sel;
    load_level       <= load;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
    w = next_ramp_word(op, dir, sel, load);
    pending_words.push_back(typed ? want : w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_FLOOR:   floor_q   = value;
      CFG_CEILING: ceiling_q = value;
      CFG_STEPS:   steps_q   = value;
      default:     style_q   = value[0];
    endcase
  endtask

  task automatic apply_setting(input ramp_setting_t s);
    write_reg(CFG_FLOOR, s.floor_lvl);
    write_reg(CFG_CEILING, s.ceiling_lvl);
    write_reg(CFG_STEPS, s.steps);
    write_reg(CFG_STYLE, {7'd0, s.stepped});
    cfg_we <= 1'b0;
  endtask

  // stop offering, let every result come back and the sequencer go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly start / ticks / stop runs with random content, some stray words
  task automatic run_ramp_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned ticks;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        offer_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), pick_level(), 1'b0, '0);
        sent++;
      end else begin
        offer_word(OP_START, 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                   8'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
        ticks = $urandom_range(1, 20);
        repeat (ticks) begin
          if ($urandom_range(0, 9) == 0)
            offer_word(OP_LOAD, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       pick_level(), 1'b0, '0);
          else
            offer_word(OP_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 1'b0, '0);
          sent++;
        end
        // some runs are left open on purpose
        if ($urandom_range(0, 3) != 0) begin
          offer_word(OP_STOP, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        oldest_word = pending_words.pop_front();
        check_field("brightness", 32'(oldest_word.level), 32'(brightness));
        check_field("frequency_index", 32'(oldest_word.freq), 32'(frequency_index));
        check_field("direction_now", 32'(oldest_word.dir), 32'($unsigned(direction_now)));
        check_field("remembered_level", 32'(oldest_word.memory), 32'(remembered_level));
        check_field("led_update", 32'(oldest_word.led), 32'(led_update));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request, none at the end
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    ramp_setting_t s;
    floor_q   = FLOOR_RESET;
    ceiling_q = CEIL_RESET;
    steps_q   = STEPS_RESET;
    style_q   = 1'b1;
    level_q   = 8'd0;
    freq_q    = FREQ_RESET;
    dir_q     = DIR_HOLD;
    running_q = 1'b0;
    on_freq_q = 1'b0;
    memory_q  = MEM_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].op, directed_rows[i].dir, directed_rows[i].sel,
                 directed_rows[i].load, directed_rows[i].typed, directed_rows[i].want);
    drain();

    for (int p = 0; p < 9; p++) begin
      if (p < 7) s = fixed_settings[p];
      else begin
        s.floor_lvl   = pick_level();
        s.ceiling_lvl = ($urandom_range(0, 3) == 0) ? pick_level()
                        : 8'($urandom_range(s.floor_lvl, 255));
        s.steps       = ($urandom_range(0, 4) == 0) ? pick_level()
                        : 8'($urandom_range(0, 12));
        s.stepped     = 1'($urandom_range(0, 1));
      end
      apply_setting(s);
      // the receiver sits on a word while the sender keeps offering
      if (p == 0) hold_req = 1'b1;
      run_ramp_traffic(PHASE_WORDS);
      drain();
    end

    // frequency sweep touching both ends, with no idling on either side
    quiet = 1'b1;
    apply_setting('{8'd1, 8'd255, 8'd7, 1'b1});
    offer_word(OP_START, DIR_UP, 1'b1, 8'd0, 1'b0, '0);
    repeat (SWEEP_TICKS) offer_word(OP_TICK, DIR_HOLD, 1'b0, 8'd0, 1'b0, '0);
    offer_word(OP_START, DIR_DOWN, 1'b1, 8'd0, 1'b0, '0);
    repeat (SWEEP_TICKS) offer_word(OP_TICK, DIR_HOLD, 1'b0, 8'd0, 1'b0, '0);
    offer_word(OP_STOP, DIR_HOLD, 1'b0, 8'd0, 1'b0, '0);
    drain();

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/blr_pkg.sv
hw/rtl/bouncing_level_ramp.sv
hw/rtl/blr_checker.sv
test/bouncing_level_ramp_test.sv
